FILE: rtl/bdht_pkg.sv
package bdht_pkg;

  localparam int unsigned STABLE_W = 17;
  localparam int unsigned HOLD_W   = 32;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

  typedef enum logic [2:0] {
    OP_SAMPLE        = 3'd0,
    OP_TAKE_PRESS    = 3'd1,
    OP_TAKE_RELEASE  = 3'd2,
    OP_FORCE_PRESS   = 3'd3,
    OP_FORCE_RELEASE = 3'd4,
    OP_RESYNC        = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PH_WAIT_PRESS     = 3'd0,
    PH_PRESS_STABLE   = 3'd1,
    PH_HOLD           = 3'd2,
    PH_RELEASE_STABLE = 3'd3,
    PH_RESYNC         = 3'd4
  } phase_t;

  typedef enum logic {
    CFG_ACTIVE_LOW  = 1'b0,
    CFG_DEBOUNCE_MS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              held;
    logic [HOLD_W-1:0] hold_now;
    logic              press_taken;
    logic              release_taken;
    logic [HOLD_W-1:0] release_hold;
  } result_t;

endpackage

FILE: rtl/button_debouncer_hold_timer.sv
// Push-button debouncer with hold timer. Each input transaction carries an op
// (sample, take press, take release, force press, force release, resync); a sample
// gives the raw pin level and the milliseconds since the previous sample. A press
// or release counts once its level has been stable for longer than debounce_ms, and
// the hold time saturates at 0xFFFFFFFF. Every input transaction yields exactly one
// result transaction showing the state after the op. A transaction is registered on
// entry, processed by a single update of the debounce state as it leaves there and
// registered at the output. One transaction is taken per cycle while the output is
// drained. Configuration (index 0 active_low, index 1 debounce_ms, reset 0 and 20)
// is to be written only while the block is idle; the block does not enforce this.
module button_debouncer_hold_timer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_index,
  input  logic [bdht_pkg::DEBOUNCE_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_op,
  input  logic                                 in_pin_level,
  input  logic [bdht_pkg::ELAPSED_W-1:0]       in_elapsed_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_held,
  output logic [bdht_pkg::HOLD_W-1:0]          out_hold_now,
  output logic                                 out_press_taken,
  output logic                                 out_release_taken,
  output logic [bdht_pkg::HOLD_W-1:0]          out_release_hold
);

  logic                                 active_low_r;
  logic [bdht_pkg::DEBOUNCE_W-1:0]      debounce_r;

  logic                                 s1_valid_r;
  logic [2:0]                           s1_op_r;
  logic                                 s1_pin_r;
  logic [bdht_pkg::ELAPSED_W-1:0]       s1_elapsed_r;
  logic                                 s1_adv;

  bdht_pkg::result_t                    core_result;
  bdht_pkg::result_t                    out_r;
  logic                                 out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r <= 1'b0;
      debounce_r   <= bdht_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      case (bdht_pkg::cfg_idx_t'(cfg_index))
        bdht_pkg::CFG_ACTIVE_LOW:  active_low_r <= cfg_data[0];
        bdht_pkg::CFG_DEBOUNCE_MS: debounce_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r      <= in_op;
      s1_pin_r     <= in_pin_level;
      s1_elapsed_r <= in_elapsed_ms;
    end
  end

  bdht_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (s1_adv),
    .active_low  (active_low_r),
    .debounce_ms (debounce_r),
    .op          (s1_op_r),
    .pin_level   (s1_pin_r),
    .elapsed_ms  (s1_elapsed_r),
    .result      (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= core_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_held          = out_r.held;
  assign out_hold_now      = out_r.hold_now;
  assign out_press_taken   = out_r.press_taken;
  assign out_release_taken = out_r.release_taken;
  assign out_release_hold  = out_r.release_hold;

endmodule

FILE: rtl/bdht_core.sv
module bdht_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                active_low,
  input  logic [bdht_pkg::DEBOUNCE_W-1:0]     debounce_ms,
  input  logic [2:0]                          op,
  input  logic                                pin_level,
  input  logic [bdht_pkg::ELAPSED_W-1:0]      elapsed_ms,
  output bdht_pkg::result_t                   result
);

  bdht_pkg::phase_t                  phase_r, phase_nxt;
  logic [bdht_pkg::STABLE_W-1:0]     stable_r, stable_nxt;
  logic [bdht_pkg::HOLD_W-1:0]       hold_r, hold_nxt;
  logic                              press_flag_r, press_flag_nxt;
  logic                              release_flag_r, release_flag_nxt;

  logic                              pressed;
  logic [bdht_pkg::STABLE_W:0]       stable_sum;
  logic [bdht_pkg::STABLE_W-1:0]     stable_sat;
  logic [bdht_pkg::HOLD_W:0]         hold_sum;
  logic [bdht_pkg::HOLD_W-1:0]       hold_sat;
  logic                              stable_done;

  assign pressed    = active_low ? ~pin_level : pin_level;
  assign stable_sum = {1'b0, stable_r} +
                      {{(bdht_pkg::STABLE_W + 1 - bdht_pkg::ELAPSED_W){1'b0}}, elapsed_ms};
  assign stable_sat = stable_sum[bdht_pkg::STABLE_W] ? '1 :
                      stable_sum[bdht_pkg::STABLE_W-1:0];
  assign hold_sum   = {1'b0, hold_r} +
                      {{(bdht_pkg::HOLD_W + 1 - bdht_pkg::ELAPSED_W){1'b0}}, elapsed_ms};
  assign hold_sat   = hold_sum[bdht_pkg::HOLD_W] ? '1 : hold_sum[bdht_pkg::HOLD_W-1:0];
  assign stable_done = stable_sat >
                       {{(bdht_pkg::STABLE_W - bdht_pkg::DEBOUNCE_W){1'b0}}, debounce_ms};

  always_comb begin
    phase_nxt        = phase_r;
    stable_nxt       = stable_r;
    hold_nxt         = hold_r;
    press_flag_nxt   = press_flag_r;
    release_flag_nxt = release_flag_r;
    case (bdht_pkg::op_t'(op))
      bdht_pkg::OP_SAMPLE: begin
        case (phase_r)
          bdht_pkg::PH_PRESS_STABLE: begin
            if (pressed) begin
              stable_nxt = stable_sat;
              if (stable_done) begin
                phase_nxt      = bdht_pkg::PH_HOLD;
                hold_nxt       = {{(bdht_pkg::HOLD_W - bdht_pkg::STABLE_W){1'b0}}, stable_sat};
                press_flag_nxt = 1'b1;
              end
            end else begin
              phase_nxt = bdht_pkg::PH_WAIT_PRESS;
            end
          end
          bdht_pkg::PH_HOLD: begin
            if (pressed) begin
              hold_nxt = hold_sat;
            end else begin
              phase_nxt  = bdht_pkg::PH_RELEASE_STABLE;
              stable_nxt = '0;
            end
          end
          bdht_pkg::PH_RELEASE_STABLE, bdht_pkg::PH_RESYNC: begin
            if (!pressed) begin
              stable_nxt = stable_sat;
              if (stable_done) begin
                if (phase_r == bdht_pkg::PH_RELEASE_STABLE) begin
                  release_flag_nxt = 1'b1;
                end
                phase_nxt = bdht_pkg::PH_WAIT_PRESS;
              end
            end else begin
              stable_nxt = '0;
            end
          end
          default: begin
            if (pressed) begin
              phase_nxt  = bdht_pkg::PH_PRESS_STABLE;
              stable_nxt = '0;
            end else begin
              phase_nxt = bdht_pkg::PH_WAIT_PRESS;
            end
          end
        endcase
      end
      bdht_pkg::OP_TAKE_PRESS: begin
        press_flag_nxt = 1'b0;
      end
      bdht_pkg::OP_TAKE_RELEASE: begin
        release_flag_nxt = 1'b0;
      end
      bdht_pkg::OP_FORCE_PRESS: begin
        phase_nxt      = bdht_pkg::PH_HOLD;
        hold_nxt       = '0;
        press_flag_nxt = 1'b1;
      end
      bdht_pkg::OP_FORCE_RELEASE: begin
        phase_nxt        = bdht_pkg::PH_WAIT_PRESS;
        release_flag_nxt = 1'b1;
      end
      bdht_pkg::OP_RESYNC: begin
        phase_nxt        = bdht_pkg::PH_RESYNC;
        press_flag_nxt   = 1'b0;
        release_flag_nxt = 1'b0;
        hold_nxt         = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.held          = (phase_nxt == bdht_pkg::PH_HOLD);
    result.hold_now      = result.held ? hold_nxt : '0;
    result.press_taken   = (op == bdht_pkg::OP_TAKE_PRESS) ? press_flag_r : 1'b0;
    result.release_taken = (op == bdht_pkg::OP_TAKE_RELEASE) ? release_flag_r : 1'b0;
    result.release_hold  = ((op == bdht_pkg::OP_TAKE_RELEASE) && release_flag_r) ?
                           hold_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bdht_pkg::PH_WAIT_PRESS;
      stable_r       <= '0;
      hold_r         <= '0;
      press_flag_r   <= 1'b0;
      release_flag_r <= 1'b0;
    end else if (en) begin
      phase_r        <= phase_nxt;
      stable_r       <= stable_nxt;
      hold_r         <= hold_nxt;
      press_flag_r   <= press_flag_nxt;
      release_flag_r <= release_flag_nxt;
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  OP_UNUSED_6 = 3'd6;
  localparam logic [2:0]  OP_UNUSED_7 = 3'd7;
  localparam logic [16:0] STABLE_SAT = '1;
  localparam logic [31:0] HOLD_SAT = '1;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned HOLD_SAMPLES = 40;
  localparam int unsigned PHASE_ITEMS = 86;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_CHECKED, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  op;
    logic        lvl;
    logic [15:0] el;
    logic        held;
    logic [31:0] hold_now;
    logic        press_taken;
    logic        release_taken;
    logic [31:0] release_hold;
  } row_t;

  // Configuration rows carry active_low in lvl and debounce_ms in el.
  localparam row_t DIRECTED_ROWS [26] = '{
    '{ROW_CHECKED,   bdht_pkg::OP_TAKE_PRESS,    1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED,   OP_UNUSED_7,                1'b1, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED,   bdht_pkg::OP_SAMPLE,        1'b1, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'd20,   1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'd1,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_TAKE_PRESS,    1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'd5,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b0, 16'd21,   1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_TAKE_RELEASE,  1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED,   bdht_pkg::OP_TAKE_RELEASE,  1'b1, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED,   bdht_pkg::OP_FORCE_PRESS,   1'b1, 16'hFFFF, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_FORCE_RELEASE, 1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_TAKE_RELEASE,  1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CONFIG,    bdht_pkg::OP_SAMPLE,        1'b1, 16'd255,  1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b0, 16'd255,  1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b0, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_RESYNC,        1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'hFFFF, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED,   bdht_pkg::OP_TAKE_RELEASE,  1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_CONFIG,    bdht_pkg::OP_SAMPLE,        1'b0, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'd7,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'd0,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0},
    '{ROW_PREDICTED, bdht_pkg::OP_SAMPLE,        1'b1, 16'd1,    1'b0, 32'd0, 1'b0, 1'b0, 32'd0}
  };

  localparam logic       PHASE_ACTIVE_LOW [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic [7:0] PHASE_DEBOUNCE [8] = '{8'd20, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd5, 8'd255};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic        in_pin_level = 1'b0;
  logic [15:0] in_elapsed_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_held;
  logic [31:0] out_hold_now;
  logic        out_press_taken;
  logic        out_release_taken;
  logic [31:0] out_release_hold;

  logic              literal_valid = 1'b0;
  bdht_pkg::result_t literal_report = '0;

  logic              m_active_low = 1'b0;
  logic [7:0]        m_debounce = bdht_pkg::DEBOUNCE_RESET;
  bdht_pkg::phase_t  m_phase = bdht_pkg::PH_WAIT_PRESS;
  logic [16:0]       m_stable = '0;
  logic [31:0]       m_hold = '0;
  logic              m_press = 1'b0;
  logic              m_release = 1'b0;

  bdht_pkg::result_t expected_reports [$];
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  logic btn_down = 1'b0;

  button_debouncer_hold_timer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_pin_level      (in_pin_level),
    .in_elapsed_ms     (in_elapsed_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_held          (out_held),
    .out_hold_now      (out_hold_now),
    .out_press_taken   (out_press_taken),
    .out_release_taken (out_release_taken),
    .out_release_hold  (out_release_hold)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [16:0] stable_sum(logic [15:0] el);
    logic [17:0] s;
    s = {1'b0, m_stable} + el;
    return (s > STABLE_SAT) ? STABLE_SAT : s[16:0];
  endfunction

  function automatic bdht_pkg::result_t debounce_step(logic [2:0] op, logic lvl,
                                                      logic [15:0] el);
    bdht_pkg::result_t r;
    logic pressed;
    logic [32:0] h;
    r = '0;
    pressed = m_active_low ? ~lvl : lvl;
    h = {1'b0, m_hold} + el;
    case (op)
      bdht_pkg::OP_SAMPLE: begin
        case (m_phase)
          bdht_pkg::PH_PRESS_STABLE: begin
            if (pressed) begin
              m_stable = stable_sum(el);
              if (m_stable > m_debounce) begin
                m_phase = bdht_pkg::PH_HOLD;
                m_hold = {15'd0, m_stable};
                m_press = 1'b1;
              end
            end else begin
              m_phase = bdht_pkg::PH_WAIT_PRESS;
            end
          end
          bdht_pkg::PH_HOLD: begin
            if (pressed) begin
              m_hold = h[32] ? HOLD_SAT : h[31:0];
            end else begin
              m_phase = bdht_pkg::PH_RELEASE_STABLE;
              m_stable = '0;
            end
          end
          bdht_pkg::PH_RELEASE_STABLE, bdht_pkg::PH_RESYNC: begin
            if (!pressed) begin
              m_stable = stable_sum(el);
              if (m_stable > m_debounce) begin
                if (m_phase == bdht_pkg::PH_RELEASE_STABLE) m_release = 1'b1;
                m_phase = bdht_pkg::PH_WAIT_PRESS;
              end
            end else begin
              m_stable = '0;
            end
          end
          default: begin
            m_phase = bdht_pkg::PH_WAIT_PRESS;
            if (pressed) begin
              m_phase = bdht_pkg::PH_PRESS_STABLE;
              m_stable = '0;
            end
          end
        endcase
      end
      bdht_pkg::OP_TAKE_PRESS: begin
        r.press_taken = m_press;
        m_press = 1'b0;
      end
      bdht_pkg::OP_TAKE_RELEASE: begin
        r.release_taken = m_release;
        if (m_release) r.release_hold = m_hold;
        m_release = 1'b0;
      end
      bdht_pkg::OP_FORCE_PRESS: begin
        m_phase = bdht_pkg::PH_HOLD;
        m_hold = '0;
        m_press = 1'b1;
      end
      bdht_pkg::OP_FORCE_RELEASE: begin
        m_phase = bdht_pkg::PH_WAIT_PRESS;
        m_release = 1'b1;
      end
      bdht_pkg::OP_RESYNC: begin
        m_phase = bdht_pkg::PH_RESYNC;
        m_press = 1'b0;
        m_release = 1'b0;
        m_hold = '0;
      end
      default: begin
      end
    endcase
    r.held = (m_phase == bdht_pkg::PH_HOLD);
    r.hold_now = r.held ? m_hold : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bdht_pkg::result_t predicted;
    bdht_pkg::result_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_index == bdht_pkg::CFG_ACTIVE_LOW) m_active_low = cfg_data[0];
        else m_debounce = cfg_data;
      end
      if (in_valid && in_ready) begin
        predicted = debounce_step(in_op, in_pin_level, in_elapsed_ms);
        expected_reports.push_back(literal_valid ? literal_report : predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected transaction, held %0d hold_now %0d", $time, out_held,
                   out_hold_now);
          n_errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("held", 32'(want.held), 32'(out_held));
          check_field("hold_now", want.hold_now, out_hold_now);
          check_field("press_taken", 32'(want.press_taken), 32'(out_press_taken));
          check_field("release_taken", 32'(want.release_taken), 32'(out_release_taken));
          check_field("release_hold", want.release_hold, out_release_hold);
          n_checked++;
        end
      end
    end
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic present_item(input logic [2:0] op, input logic lvl, input logic [15:0] el,
                              input logic literal, input bdht_pkg::result_t report);
    int unsigned gap;
    gap = (sender_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pin_level <= lvl;
    in_elapsed_ms <= el;
    literal_valid <= literal;
    literal_report <= report;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_checked != n_sent);
  endtask

  task automatic set_config(input logic al, input logic [7:0] db);
    cfg_wr_en <= 1'b1;
    cfg_index <= bdht_pkg::CFG_ACTIVE_LOW;
    cfg_data <= {7'd0, al};
    @(posedge clk);
    cfg_index <= bdht_pkg::CFG_DEBOUNCE_MS;
    cfg_data <= db;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_item(input logic al, input logic [7:0] db);
    logic [2:0] op;
    logic lvl;
    logic [15:0] el;
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    lvl = 1'($urandom_range(0, 1));
    el = 16'($urandom_range(0, 65535));
    if (r < 78) begin
      op = bdht_pkg::OP_SAMPLE;
      if ($urandom_range(0, 7) == 0) btn_down = ~btn_down;
      lvl = btn_down ^ ($urandom_range(0, 9) == 0) ^ al;
      span = $urandom_range(0, 19);
      if (span < 15) el = 16'($urandom_range(0, db / 3 + 3));
      else if (span < 19) el = 16'($urandom_range(0, 2 * db + 2));
      else if ($urandom_range(0, 1) == 0) el = 16'hFFFF;
    end else if (r < 85) begin
      op = bdht_pkg::OP_TAKE_PRESS;
    end else if (r < 91) begin
      op = bdht_pkg::OP_TAKE_RELEASE;
    end else if (r < 94) begin
      op = bdht_pkg::OP_FORCE_PRESS;
    end else if (r < 96) begin
      op = bdht_pkg::OP_FORCE_RELEASE;
    end else if (r < 98) begin
      op = bdht_pkg::OP_RESYNC;
    end else begin
      op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    end
    present_item(op, lvl, el, 1'b0, '0);
  endtask

  initial begin : stimulus
    bdht_pkg::result_t report;
    logic [7:0] db;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CONFIG) begin
        drain();
        set_config(DIRECTED_ROWS[i].lvl, DIRECTED_ROWS[i].el[7:0]);
      end else begin
        report = {DIRECTED_ROWS[i].held, DIRECTED_ROWS[i].hold_now, DIRECTED_ROWS[i].press_taken,
                  DIRECTED_ROWS[i].release_taken, DIRECTED_ROWS[i].release_hold};
        present_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].lvl, DIRECTED_ROWS[i].el,
                     DIRECTED_ROWS[i].kind == ROW_CHECKED, report);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      db = (ph == 4 || ph == 5) ? 8'($urandom_range(2, 254)) : PHASE_DEBOUNCE[ph];
      set_config(PHASE_ACTIVE_LOW[ph], db);
      sender_idle_on = (ph != 3 && ph != 5);
      receiver_idle_on = (ph != 5);
      long_hold_req = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_random_item(PHASE_ACTIVE_LOW[ph], db);
        if (ph == 2 && k == PHASE_ITEMS / 2) drain();
      end
    end

    // Grow the hold time with back-to-back maximum samples, then release and read it.
    drain();
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    set_config(1'b0, bdht_pkg::DEBOUNCE_RESET);
    present_item(bdht_pkg::OP_FORCE_PRESS, 1'b0, 16'd0, 1'b0, '0);
    repeat (HOLD_SAMPLES) present_item(bdht_pkg::OP_SAMPLE, 1'b1, 16'hFFFF, 1'b0, '0);
    present_item(bdht_pkg::OP_SAMPLE, 1'b0, 16'd0, 1'b0, '0);
    present_item(bdht_pkg::OP_SAMPLE, 1'b0, 16'd200, 1'b0, '0);
    present_item(bdht_pkg::OP_TAKE_RELEASE, 1'b0, 16'd0, 1'b0, '0);

    drain();
    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_reports.size() == 0) begin
      $display("button_debouncer_hold_timer: match");
    end else begin
      $display("button_debouncer_hold_timer: mismatch");
    end
    $finish;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("button_debouncer_hold_timer: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bdht_pkg.sv
rtl/bdht_core.sv
rtl/button_debouncer_hold_timer.sv
test/tb.sv
